### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("check failed");

`endif

### hdl/drap_pkg.sv
package drap_pkg;

    localparam int MAX_PACKET_DEF = 512;

    localparam int HDR_LEN = 12;
    localparam int HDR_IDX_W = 4;

    localparam logic [7:0] PTR_MARK = 8'hC0;
    localparam logic [15:0] QR_MASK = 16'h8000;
    localparam logic [15:0] RCODE_MASK = 16'h000F;
    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] A_RDLEN = 16'd4;

    typedef struct packed {
        logic take;
        logic parse;
        logic last;
    } t_step_ctl;

    typedef struct packed {
        logic found;
        logic [31:0] address;
    } t_step_res;

endpackage

### hdl/drap_if.sv
interface drap_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic last_byte;
    logic [15:0] query_id;

    modport source (output valid, output data_byte, output last_byte, output query_id,
                    input ready);
    modport sink (input valid, input data_byte, input last_byte, input query_id,
                  output ready);
endinterface

interface drap_out_if;
    logic valid;
    logic ready;
    logic status;
    logic [31:0] address;

    modport source (output valid, output status, output address, input ready);
    modport sink (input valid, input status, input address, output ready);
endinterface

### hdl/drap_step.sv
module drap_step
    import drap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_step_ctl            i_ctl,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_query_id,
    input  logic [HDR_IDX_W-1:0] i_hdr_idx,
    output t_step_res            o_res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_AFIXED,
        PH_RDSKIP,
        PH_RDATA,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OUT_PENDING,
        OUT_FOUND,
        OUT_FAILED
    } t_outcome;

    localparam logic [HDR_IDX_W-1:0] HB_ID_HI = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HB_ID_LO = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HB_FLAGS_HI = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HB_FLAGS_LO = HDR_IDX_W'(3);
    localparam logic [HDR_IDX_W-1:0] HB_QD_HI = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] HB_QD_LO = HDR_IDX_W'(5);
    localparam logic [HDR_IDX_W-1:0] HB_AN_HI = HDR_IDX_W'(6);
    localparam logic [HDR_IDX_W-1:0] HB_AN_LO = HDR_IDX_W'(7);
    localparam logic [HDR_IDX_W-1:0] HB_LAST = HDR_IDX_W'(HDR_LEN - 1);

    localparam logic [3:0] QFIXED_END = 4'd5;
    localparam logic [3:0] AFIXED_END = 4'd11;
    localparam logic [3:0] TYPE_END = 4'd2;
    localparam logic [3:0] RDLEN_START = 4'd9;
    localparam logic [3:0] RDATA_END = 4'd4;

    t_phase r_phase, n_phase;
    t_outcome r_outcome, n_outcome;
    logic [3:0] r_field, n_field;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_qleft, n_qleft;
    logic [15:0] r_aleft, n_aleft;
    logic [7:0] r_held, n_held;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_rlen, n_rlen;
    logic [31:0] r_addr, n_addr;

    logic [3:0] w_field_inc;
    logic [15:0] w_qdec;
    logic [15:0] w_adec;
    logic [15:0] w_flags;

    assign w_field_inc = r_field + 4'd1;
    assign w_qdec = r_qleft - 16'd1;
    assign w_adec = r_aleft - 16'd1;
    assign w_flags = {r_held, i_data_byte};

    always_comb begin
        n_phase = r_phase;
        n_outcome = r_outcome;
        n_field = r_field;
        n_skip = r_skip;
        n_qleft = r_qleft;
        n_aleft = r_aleft;
        n_held = r_held;
        n_rtype = r_rtype;
        n_rlen = r_rlen;
        n_addr = r_addr;

        unique case (r_phase) inside
            PH_HEADER: begin
                unique case (i_hdr_idx) inside
                    HB_ID_HI: begin
                        if (i_data_byte != i_query_id[15:8]) begin
                            n_outcome = OUT_FAILED;
                            n_phase = PH_DONE;
                        end
                    end
                    HB_ID_LO: begin
                        if (i_data_byte != i_query_id[7:0]) begin
                            n_outcome = OUT_FAILED;
                            n_phase = PH_DONE;
                        end
                    end
                    HB_FLAGS_HI: n_held = i_data_byte;
                    HB_FLAGS_LO: begin
                        if ((w_flags & QR_MASK) == 16'd0 || (w_flags & RCODE_MASK) != 16'd0) begin
                            n_outcome = OUT_FAILED;
                            n_phase = PH_DONE;
                        end
                    end
                    HB_QD_HI, HB_QD_LO: n_qleft = {r_qleft[7:0], i_data_byte};
                    HB_AN_HI, HB_AN_LO: n_aleft = {r_aleft[7:0], i_data_byte};
                    default: ;
                endcase
                if (i_hdr_idx == HB_LAST && n_phase == PH_HEADER) begin
                    if (n_aleft == 16'd0) begin
                        n_outcome = OUT_FAILED;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = (n_qleft == 16'd0) ? PH_ANAME : PH_QNAME;
                    end
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (r_skip != 16'd0) begin
                    n_skip = r_skip - 16'd1;
                end else if (i_data_byte == 8'd0 || (i_data_byte & PTR_MARK) == PTR_MARK) begin
                    // pointer takes one more byte, so the fixed part starts a step early
                    n_field = (i_data_byte == 8'd0) ? 4'd1 : 4'd0;
                    n_phase = (r_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                end else begin
                    n_skip = {8'd0, i_data_byte};
                end
            end
            PH_QFIXED: begin
                n_field = w_field_inc;
                if (w_field_inc >= QFIXED_END) begin
                    n_qleft = w_qdec;
                    n_phase = (w_qdec == 16'd0) ? PH_ANAME : PH_QNAME;
                end
            end
            PH_AFIXED: begin
                if (r_field >= 4'd1) begin
                    if (r_field <= TYPE_END) begin
                        n_rtype = {r_rtype[7:0], i_data_byte};
                    end else if (r_field >= RDLEN_START) begin
                        n_rlen = {r_rlen[7:0], i_data_byte};
                    end
                end
                n_field = w_field_inc;
                if (w_field_inc >= AFIXED_END) begin
                    if (n_rtype == TYPE_A && n_rlen == A_RDLEN) begin
                        n_addr = 32'd0;
                        n_field = 4'd0;
                        n_phase = PH_RDATA;
                    end else begin
                        n_aleft = w_adec;
                        if (w_adec == 16'd0) begin
                            n_outcome = OUT_FAILED;
                            n_phase = PH_DONE;
                        end else if (n_rlen == 16'd0) begin
                            n_phase = PH_ANAME;
                        end else begin
                            n_skip = n_rlen;
                            n_phase = PH_RDSKIP;
                        end
                    end
                end
            end
            PH_RDSKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = PH_ANAME;
                end
            end
            PH_RDATA: begin
                n_addr = {r_addr[23:0], i_data_byte};
                n_field = w_field_inc;
                if (w_field_inc >= RDATA_END) begin
                    n_outcome = OUT_FOUND;
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        if (i_ctl.parse) begin
            o_res.found = (n_outcome == OUT_FOUND);
            o_res.address = n_addr;
        end else begin
            o_res.found = (r_outcome == OUT_FOUND);
            o_res.address = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.take && i_ctl.last)) begin
            r_phase <= PH_HEADER;
            r_outcome <= OUT_PENDING;
            r_field <= 4'd0;
            r_skip <= 16'd0;
            r_qleft <= 16'd0;
            r_aleft <= 16'd0;
            r_held <= 8'd0;
            r_rtype <= 16'd0;
            r_rlen <= 16'd0;
            r_addr <= 32'd0;
        end else if (i_ctl.parse) begin
            r_phase <= n_phase;
            r_outcome <= n_outcome;
            r_field <= n_field;
            r_skip <= n_skip;
            r_qleft <= n_qleft;
            r_aleft <= n_aleft;
            r_held <= n_held;
            r_rtype <= n_rtype;
            r_rlen <= n_rlen;
            r_addr <= n_addr;
        end
    end

endmodule

### hdl/dns_response_a_record_parser.sv
// channel   | dir | fields                                 | accepted when
// i_item    | in  | data_byte, last_byte, query_id         | valid && ready
// o_result  | out | status, address                        | valid && ready
//
// one byte per cycle unless a result stalls; parsing runs off the input register
// a packet's result is registered once its last byte leaves the input register
// reset is synchronous and clears the parser, the byte count and both valids
// a stalled result holds the last byte of the next packet in the input register;
// other bytes keep flowing
module dns_response_a_record_parser
    import drap_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    drap_in_if.sink         i_item,
    drap_out_if.source      o_result
);

    localparam int CNT_W = $clog2(MAX_PACKET + 1);

    logic r_in_valid;
    logic [7:0] r_in_byte;
    logic r_in_last;
    logic [15:0] r_in_eid;
    logic [CNT_W-1:0] r_count;
    logic r_out_valid;
    logic r_out_status;
    logic [31:0] r_out_address;

    logic w_proceed;
    logic w_accept;
    t_step_ctl w_ctl;
    t_step_res w_res;

    assign w_proceed = !r_in_last || !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || w_proceed;
    assign w_accept = i_item.valid && i_item.ready;

    assign w_ctl.take = r_in_valid && w_proceed;
    assign w_ctl.parse = w_ctl.take && (r_count < CNT_W'(MAX_PACKET));
    assign w_ctl.last = r_in_last;

    drap_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_data_byte   (r_in_byte),
        .i_query_id    (r_in_eid),
        .i_hdr_idx     (r_count[HDR_IDX_W-1:0]),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_ctl.take) begin
                if (r_in_last) begin
                    r_count <= '0;
                end else if (w_ctl.parse) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (w_ctl.take && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_item.data_byte;
            r_in_last <= i_item.last_byte;
            r_in_eid <= i_item.query_id;
        end
        if (w_ctl.take && r_in_last) begin
            r_out_status <= !w_res.found;
            r_out_address <= w_res.found ? w_res.address : 32'd0;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.status = r_out_status;
    assign o_result.address = r_out_address;

endmodule

### hdl/drap_checker.sv
`include "assert_macros.svh"

module drap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_status,
    input logic [31:0] i_out_address
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `CHK_ASSERT(a_fail_zero, i_clk, i_rst_n, i_out_valid && i_out_status |-> i_out_address == 32'd0)
    `CHK_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
    `CHK_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind dns_response_a_record_parser drap_checker u_drap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_in_last     (i_item.last_byte),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_status  (o_result.status),
    .i_out_address (o_result.address)
);

### dv/dns_response_a_record_parser_tb.sv
module dns_response_a_record_parser_tb;
    import drap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_LIMIT = MAX_PACKET_DEF;
    localparam int unsigned RUN_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES = 300;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_FAILED = 1'b1;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [15:0] AAAA_RDLEN = 16'd16;
    localparam logic [7:0] NAME_END = 8'h00;

    typedef enum logic [2:0] {
        ST_HEADER, ST_QNAME, ST_QFIXED, ST_ANAME, ST_AFIXED, ST_RDSKIP, ST_RDATA, ST_DONE
    } parse_state_t;

    typedef enum logic [1:0] {V_PENDING, V_FOUND, V_FAILED} verdict_t;

    typedef enum logic [2:0] {
        HF_NONE, HF_ID_HI, HF_ID_LO, HF_NO_QR, HF_RCODE, HF_NO_ANSWERS
    } header_fault_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} sink_mode_t;

    typedef struct packed {
        logic        status;
        logic [31:0] address;
    } lookup_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drap_in_if item_if ();
    drap_out_if result_if ();

    dns_response_a_record_parser #(
        .MAX_PACKET(PKT_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_item(item_if),
        .o_result(result_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser mirror
    parse_state_t ps;
    logic [10:0]  seen;
    logic [3:0]   fidx;
    logic [15:0]  skip_left;
    logic [15:0]  qd_left;
    logic [15:0]  an_left;
    logic [7:0]   flags_hi;
    logic [15:0]  rr_type;
    logic [15:0]  rr_len;
    logic [31:0]  addr_acc;
    verdict_t     verdict;

    lookup_t expected_lookups[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    bit          idle_on;
    int unsigned burst_left;
    sink_mode_t  rx_mode;
    int unsigned rx_hold_req;
    int unsigned rx_hold_left;
    int unsigned rx_phase;

    logic [7:0] pkt[$];

    function automatic void clear_parser();
        ps = ST_HEADER;
        seen = '0;
        fidx = '0;
        skip_left = '0;
        qd_left = '0;
        an_left = '0;
        flags_hi = '0;
        rr_type = '0;
        rr_len = '0;
        addr_acc = '0;
        verdict = V_PENDING;
    endfunction

    function automatic void give_up();
        verdict = V_FAILED;
        ps = ST_DONE;
    endfunction

    function automatic bit name_ends(input logic [7:0] b, output bit by_ptr);
        by_ptr = 1'b0;
        if (skip_left != 0) begin
            skip_left = skip_left - 16'd1;
            return 1'b0;
        end
        if (b == NAME_END)
            return 1'b1;
        if ((b & PTR_MARK) == PTR_MARK) begin
            by_ptr = 1'b1;
            return 1'b1;
        end
        skip_left = {8'h00, b};
        return 1'b0;
    endfunction

    function automatic void check_header(input logic [7:0] b, input logic [15:0] eid);
        case (seen)
            0: if (b != eid[15:8]) give_up();
            1: if (b != eid[7:0]) give_up();
            2: flags_hi = b;
            3: begin
                if ((({flags_hi, b} & QR_MASK) == 16'h0) || (({flags_hi, b} & RCODE_MASK) != 16'h0))
                    give_up();
            end
            4, 5: qd_left = {qd_left[7:0], b};
            6, 7: an_left = {an_left[7:0], b};
            default: ;
        endcase
        if (seen == HDR_LEN - 1 && ps == ST_HEADER) begin
            if (an_left == 0)
                give_up();
            else
                ps = (qd_left == 0) ? ST_ANAME : ST_QNAME;
        end
    endfunction

    function automatic void parse_one(input logic [7:0] b, input logic [15:0] eid);
        bit by_ptr;
        case (ps)
            ST_HEADER: check_header(b, eid);
            ST_QNAME, ST_ANAME: begin
                if (name_ends(b, by_ptr)) begin
                    fidx = by_ptr ? 4'd0 : 4'd1;
                    ps = (ps == ST_QNAME) ? ST_QFIXED : ST_AFIXED;
                end
            end
            ST_QFIXED: begin
                fidx = fidx + 4'd1;
                if (fidx >= 5) begin
                    qd_left = qd_left - 16'd1;
                    ps = (qd_left == 0) ? ST_ANAME : ST_QNAME;
                end
            end
            ST_AFIXED: begin
                if (fidx >= 1 && fidx <= 2)
                    rr_type = {rr_type[7:0], b};
                else if (fidx >= 9)
                    rr_len = {rr_len[7:0], b};
                fidx = fidx + 4'd1;
                if (fidx >= 11) begin
                    if (rr_type == TYPE_A && rr_len == A_RDLEN) begin
                        addr_acc = '0;
                        fidx = '0;
                        ps = ST_RDATA;
                    end else begin
                        an_left = an_left - 16'd1;
                        if (an_left == 0) begin
                            give_up();
                        end else if (rr_len == 0) begin
                            ps = ST_ANAME;
                        end else begin
                            skip_left = rr_len;
                            ps = ST_RDSKIP;
                        end
                    end
                end
            end
            ST_RDSKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 0)
                    ps = ST_ANAME;
            end
            ST_RDATA: begin
                addr_acc = {addr_acc[23:0], b};
                fidx = fidx + 4'd1;
                if (fidx >= 4) begin
                    verdict = V_FOUND;
                    ps = ST_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit predict_lookup(input logic [7:0] b, input logic lst,
                                          input logic [15:0] eid, output lookup_t res);
        res = '0;
        if (seen < PKT_LIMIT) begin
            parse_one(b, eid);
            seen = seen + 11'd1;
        end
        if (!lst)
            return 1'b0;
        if (verdict == V_FOUND) begin
            res.status = STATUS_FOUND;
            res.address = addr_acc;
        end else begin
            res.status = STATUS_FAILED;
            res.address = '0;
        end
        clear_parser();
        return 1'b1;
    endfunction

    // packet building
    function automatic void put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_label(input int len);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_name(input int labels, input bit by_ptr, input int max_len);
        for (int i = 0; i < labels; i++)
            put_label($urandom_range(1, max_len));
        if (by_ptr) begin
            pkt.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
            pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(NAME_END);
        end
    endfunction

    function automatic void put_question(input int labels, input bit by_ptr, input int max_len);
        put_name(labels, by_ptr, max_len);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void put_answer(input int labels, input bit by_ptr, input logic [15:0] rtype,
                                       input logic [15:0] rdlen, input logic [31:0] addr);
        put_name(labels, by_ptr, 8);
        put16(rtype);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        put16(rdlen);
        if (rtype == TYPE_A && rdlen == A_RDLEN) begin
            put16(addr[31:16]);
            put16(addr[15:0]);
        end else begin
            repeat (rdlen) pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic logic [15:0] put_checked_header(input header_fault_t hf,
                                                       input logic [15:0] qd,
                                                       input logic [15:0] an);
        logic [15:0] id;
        logic [15:0] eid;
        logic [15:0] flags;
        logic [15:0] an_count;
        id = 16'($urandom);
        eid = id;
        flags = (16'($urandom) & ~RCODE_MASK) | QR_MASK;
        an_count = an;
        case (hf)
            HF_ID_HI: eid = id ^ {8'($urandom_range(1, 255)), 8'h00};
            HF_ID_LO: eid = id ^ {8'h00, 8'($urandom_range(1, 255))};
            HF_NO_QR: flags = flags & ~QR_MASK;
            HF_RCODE: flags = flags | 16'($urandom_range(1, 15));
            HF_NO_ANSWERS: an_count = '0;
            default: ;
        endcase
        put16(id);
        put16(flags);
        put16(qd);
        put16(an_count);
        put16(16'($urandom));
        put16(16'($urandom));
        return eid;
    endfunction

    function automatic void drop_tail(input int n);
        repeat (n) void'(pkt.pop_back());
    endfunction

    // driving
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [15:0] eid);
        lookup_t res;
        if (idle_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        if (burst_left != 0)
            burst_left--;
        item_if.valid <= 1'b1;
        item_if.data_byte <= b;
        item_if.last_byte <= lst;
        item_if.query_id <= eid;
        do @(posedge i_clk); while (!item_if.ready);
        if (predict_lookup(b, lst, eid, res))
            expected_lookups.push_back(res);
    endtask

    task automatic send_packet(input logic [15:0] eid);
        logic [15:0] wire_id;
        for (int i = 0; i < pkt.size(); i++) begin
            wire_id = (i >= 2 && $urandom_range(0, 3) == 0) ? 16'($urandom) : eid;
            send_byte(pkt[i], i == pkt.size() - 1, wire_id);
        end
        pkt.delete();
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        rx_phase++;
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            result_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM: result_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: result_if.ready <= ((rx_phase % 7) >= 3);
                default: result_if.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        lookup_t want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_lookups.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: status=%0b address=%08h",
                         $time, result_if.status, result_if.address);
            end else begin
                want = expected_lookups.pop_front();
                if (result_if.status !== want.status) begin
                    mismatches++;
                    $display("%0t status mismatch: expected %0b actual %0b",
                             $time, want.status, result_if.status);
                end
                if (result_if.address !== want.address) begin
                    mismatches++;
                    $display("%0t address mismatch: expected %08h actual %08h",
                             $time, want.address, result_if.address);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // tests
    task automatic test_header_checks();
        header_fault_t hf;
        logic [15:0] eid;
        hf = hf.first();
        do begin
            eid = put_checked_header(hf, 16'd1, 16'd1);
            put_question(1, 1'b0, 8);
            put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
            send_packet(eid);
            hf = hf.next();
        end while (hf != hf.first());
        // ends inside the header
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        drop_tail(7);
        send_packet(eid);
        // ends right after the header
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        send_packet(eid);
        // lone byte
        pkt.push_back(8'($urandom));
        send_packet(16'($urandom));
    endtask

    task automatic test_name_forms();
        logic [15:0] eid;
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
        send_packet(eid);
        eid = put_checked_header(HF_NONE, 16'd2, 16'd1);
        put_question(2, 1'b0, 8);
        put_question(1, 1'b1, 8);
        put_answer(3, 1'b0, TYPE_A, A_RDLEN, $urandom);
        send_packet(eid);
        // root names
        eid = put_checked_header(HF_NONE, 16'd1, 16'd1);
        put_question(0, 1'b0, 1);
        put_answer(0, 1'b0, TYPE_A, A_RDLEN, $urandom);
        send_packet(eid);
        // biggest label length that is not a pointer
        eid = put_checked_header(HF_NONE, 16'd1, 16'd1);
        put_label(191);
        put_question(0, 1'b0, 1);
        put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
        send_packet(eid);
        // ends inside a question name
        eid = put_checked_header(HF_NONE, 16'd1, 16'd1);
        put_label(20);
        drop_tail(5);
        send_packet(eid);
    endtask

    task automatic test_answer_walk();
        logic [15:0] eid;
        eid = put_checked_header(HF_NONE, 16'd1, 16'd2);
        put_question(1, 1'b0, 8);
        put_answer(1, 1'b0, TYPE_CNAME, 16'd6, '0);
        put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
        send_packet(eid);
        eid = put_checked_header(HF_NONE, 16'd0, 16'd3);
        put_answer(0, 1'b1, TYPE_A, 16'd0, '0);
        put_answer(0, 1'b1, TYPE_AAAA, AAAA_RDLEN, '0);
        put_answer(2, 1'b0, TYPE_A, A_RDLEN, 32'hFFFF_FFFF);
        send_packet(eid);
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        put_answer(0, 1'b0, TYPE_A, A_RDLEN, 32'h0000_0000);
        send_packet(eid);
        // last answer is no A record, trailing bytes ignored
        eid = put_checked_header(HF_NONE, 16'd1, 16'd1);
        put_question(0, 1'b1, 8);
        put_answer(0, 1'b1, TYPE_AAAA, AAAA_RDLEN, '0);
        repeat (5) pkt.push_back(8'($urandom));
        send_packet(eid);
        // address complete, rest ignored
        eid = put_checked_header(HF_NONE, 16'd0, 16'd2);
        put_answer(1, 1'b0, TYPE_A, A_RDLEN, $urandom);
        put_answer(0, 1'b1, TYPE_CNAME, 16'd4, '0);
        send_packet(eid);
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        put_answer(0, 1'b1, TYPE_A | 16'h0100, A_RDLEN, $urandom);
        send_packet(eid);
        // ends inside the address
        eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
        put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
        drop_tail(2);
        send_packet(eid);
        // ends before any answer
        eid = put_checked_header(HF_NONE, 16'd1, 16'd1);
        put_question(1, 1'b0, 8);
        send_packet(eid);
        // fewer answers than counted
        eid = put_checked_header(HF_NONE, 16'd0, 16'd2);
        put_answer(0, 1'b1, TYPE_CNAME, 16'd3, '0);
        send_packet(eid);
    endtask

    task automatic test_long_packets();
        logic [15:0] eid;
        // address ends on the last counted byte, trailing bytes ignored
        eid = put_checked_header(HF_NONE, 16'd1, 16'd2);
        put_question(0, 1'b0, 1);
        put_answer(0, 1'b1, TYPE_CNAME, 16'(484 - pkt.size()), '0);
        put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
        repeat (3) pkt.push_back(8'($urandom));
        send_packet(eid);
    endtask

    task automatic test_backpressure();
        logic [15:0] eid;
        idle_on = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        repeat (4) begin
            eid = put_checked_header(HF_NONE, 16'd0, 16'd1);
            put_answer(0, 1'b1, TYPE_A, A_RDLEN, $urandom);
            send_packet(eid);
        end
        idle_on = 1'b1;
    endtask

    function automatic logic [15:0] build_random_packet();
        logic [15:0] eid;
        int qd;
        int an;
        int a_at;
        int max_len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
            return 16'($urandom);
        end
        qd = $urandom_range(0, 1);
        an = $urandom_range(1, 2);
        a_at = $urandom_range(0, an);
        max_len = ($urandom_range(0, 19) == 0) ? 191 : 8;
        eid = put_checked_header(
            (r < 25) ? header_fault_t'($urandom_range(HF_ID_HI, HF_NO_ANSWERS)) : HF_NONE,
            16'(qd), 16'(an));
        repeat (qd) put_question($urandom_range(0, 2), 1'($urandom), max_len);
        for (int i = 0; i < an; i++) begin
            if (i == a_at) begin
                put_answer($urandom_range(0, 2), 1'($urandom), TYPE_A, A_RDLEN, $urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: put_answer($urandom_range(0, 2), 1'($urandom), TYPE_A,
                                  16'($urandom_range(0, 8)), $urandom);
                    1: put_answer($urandom_range(0, 2), 1'($urandom), TYPE_CNAME,
                                  16'($urandom_range(0, 8)), '0);
                    2: put_answer($urandom_range(0, 2), 1'($urandom), TYPE_AAAA,
                                  AAAA_RDLEN, '0);
                    default: put_answer($urandom_range(0, 2), 1'($urandom), 16'($urandom),
                                        16'($urandom_range(0, 8)), $urandom);
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0: drop_tail($urandom_range(0, pkt.size() - 1));
            1: repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
            default: ;
        endcase
        return eid;
    endfunction

    task automatic test_random_traffic();
        int unsigned sent_bytes;
        int unsigned sent_packets;
        logic [15:0] eid;
        sent_bytes = 0;
        sent_packets = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (sent_packets % 4 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
                rx_mode = sink_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
            end
            eid = build_random_packet();
            sent_bytes += pkt.size();
            send_packet(eid);
            sent_packets++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.data_byte = '0;
        item_if.last_byte = 1'b0;
        item_if.query_id = '0;
        result_if.ready = 1'b0;
        idle_on = 1'b1;
        burst_left = 0;
        rx_mode = RX_RANDOM;
        rx_hold_req = 0;
        rx_hold_left = 0;
        rx_phase = 0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_checks();
        test_name_forms();
        test_answer_walk();
        test_long_packets();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
